### sv/i2da_pkg.sv
// shared types and constants for the decimal ascii converter
`default_nettype none

package i2da_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int MAX_DIGITS  = 20;
	localparam int BCD_W       = 4 * MAX_DIGITS;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);
	localparam int IDX_W       = $clog2(MAX_DIGITS);

	localparam logic [6:0] ASCII_ZERO  = 7'h30;
	localparam logic [6:0] ASCII_MINUS = 7'h2d;
	localparam logic [6:0] ASCII_NINE  = 7'h39;

	typedef struct packed {
		logic [63:0] value;
		logic        mode;
	} in_word_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic scan;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic shift_last;
		logic minus;
		logic idx_zero;
	} sts_t;

endpackage

`default_nettype wire

### sv/i2da_ctrl.sv
// sequencing state machine for the decimal ascii converter
`default_nettype none

module i2da_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire i2da_pkg::sts_t sts,
	output i2da_pkg::cmd_t     cmd,
	output logic               busy
);

	i2da_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2da_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			i2da_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = i2da_pkg::ST_CONV;
				end
			end
			i2da_pkg::ST_CONV: begin
				cmd.shift = 1'b1;
				if (sts.shift_last) begin
					state_d = i2da_pkg::ST_SCAN;
				end
			end
			i2da_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = sts.minus ? i2da_pkg::ST_SIGN : i2da_pkg::ST_EMIT;
			end
			i2da_pkg::ST_SIGN: begin
				cmd.emit_sign = 1'b1;
				state_d       = i2da_pkg::ST_EMIT;
			end
			i2da_pkg::ST_EMIT: begin
				cmd.emit_digit = 1'b1;
				if (sts.idx_zero) begin
					state_d = i2da_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = i2da_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/i2da_dp.sv
// double-dabble datapath, digit scan and character output register
`default_nettype none

module i2da_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire i2da_pkg::in_word_t in_word,
	input  wire i2da_pkg::cmd_t     cmd,
	output i2da_pkg::sts_t          sts,
	output logic                    strobe,
	output i2da_pkg::out_word_t     out_word
);

	logic [i2da_pkg::VALUE_WIDTH-1:0] mag_q;
	logic [i2da_pkg::BCD_W-1:0]       bcd_q;
	logic [i2da_pkg::CNT_W-1:0]       bit_cnt_q;
	logic [i2da_pkg::IDX_W-1:0]       idx_q;
	logic                             minus_q;
	logic                             strobe_q;
	i2da_pkg::out_word_t              out_q;

	logic [i2da_pkg::VALUE_WIDTH-1:0] word;
	logic                             neg;
	logic [i2da_pkg::BCD_W-1:0]       bcd_adj;
	logic [i2da_pkg::IDX_W-1:0]       top_idx;
	logic [3:0]                       cur_digit;

	assign word = in_word.value[i2da_pkg::VALUE_WIDTH-1:0];
	assign neg  = in_word.mode & word[i2da_pkg::VALUE_WIDTH-1];

	// add-3 correction on each bcd digit before the shift
	always_comb begin
		for (int k = 0; k < i2da_pkg::MAX_DIGITS; k++) begin
			if (bcd_q[4*k +: 4] >= 4'd5) begin
				bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
			end else begin
				bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
			end
		end
	end

	// highest nonzero digit, digit zero when the whole number is zero
	always_comb begin
		top_idx = '0;
		for (int k = 0; k < i2da_pkg::MAX_DIGITS; k++) begin
			if (bcd_q[4*k +: 4] != 4'd0) begin
				top_idx = i2da_pkg::IDX_W'(k);
			end
		end
	end

	assign cur_digit = bcd_q[4*idx_q +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			idx_q     <= '0;
			minus_q   <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_sign | cmd.emit_digit;
			if (cmd.load) begin
				bit_cnt_q <= '0;
				minus_q   <= neg;
			end
			if (cmd.shift) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (cmd.scan) begin
				idx_q <= top_idx;
			end
			if (cmd.emit_digit) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= neg ? (~word + 1'b1) : word;
			bcd_q <= '0;
		end
		if (cmd.shift) begin
			bcd_q <= {bcd_adj[i2da_pkg::BCD_W-2:0], mag_q[i2da_pkg::VALUE_WIDTH-1]};
			mag_q <= {mag_q[i2da_pkg::VALUE_WIDTH-2:0], 1'b0};
		end
		if (cmd.emit_sign) begin
			out_q.char_code <= i2da_pkg::ASCII_MINUS;
			out_q.last      <= 1'b0;
		end
		if (cmd.emit_digit) begin
			out_q.char_code <= i2da_pkg::ASCII_ZERO + {3'b000, cur_digit};
			out_q.last      <= (idx_q == '0);
		end
	end

	assign sts.shift_last = (bit_cnt_q == i2da_pkg::CNT_W'(i2da_pkg::VALUE_WIDTH - 1));
	assign sts.minus      = minus_q;
	assign sts.idx_zero   = (idx_q == '0);
	assign strobe         = strobe_q;
	assign out_word       = out_q;

`ifndef NO_ASSERTIONS
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && out_q.last |=> !strobe_q)
		else $error("character strobe right after the final character");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && out_q.char_code == i2da_pkg::ASCII_MINUS |-> !out_q.last)
		else $error("minus sign marked as final character");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && out_q.char_code != i2da_pkg::ASCII_MINUS |->
		out_q.char_code >= i2da_pkg::ASCII_ZERO && out_q.char_code <= i2da_pkg::ASCII_NINE)
		else $error("bcd digit out of range");

	a_scan_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> $past(cmd.shift) && $past(sts.shift_last))
		else $error("digit scan before all bits shifted");
`endif

endmodule

`default_nettype wire

### sv/integer_to_decimal_ascii.sv
// 64-bit word to decimal ascii text, most significant character first
// order: the accepting edge loads the word, then the shift loop, the scan and the optional
// minus register run before the first character is taken, then one character per cycle
// a new word is accepted only once idle, after the last character; the one-bit-per-cycle
// shift loop sets the pace; results cannot be stalled, each is strobed once
// reset: arst_n clears state machine, counters and strobe; no clearing pass
`default_nettype none

module integer_to_decimal_ascii (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire i2da_pkg::in_word_t  in_word,
	output logic                     busy,
	output logic                     strobe,
	output i2da_pkg::out_word_t      out_word
);

	// command and status between the sequencer and the datapath
	i2da_pkg::cmd_t cmd;
	i2da_pkg::sts_t sts;

	// sequencer: idle, shift loop, scan, optional minus, digit emit
	i2da_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: magnitude and bcd shift register, digit index, output word
	i2da_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cmd      (cmd),
		.sts      (sts),
		.strobe   (strobe),
		.out_word (out_word)
	);

endmodule

`default_nettype wire
